// ===== rtl/core/bbq_pkg.sv =====
package bbq_pkg;

  // defaults for the top-level parameters
  localparam int unsigned NODES_DEF    = 1024;
  localparam int unsigned MAX_HITS_DEF = 63;

  // fixed field widths
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned OBJ_W      = 20;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned ADDR_IN_W  = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned HITS_W     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_NODE_COUNT    = 1'b0;
  localparam cfg_idx_t REG_STOP_AT_FIRST = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_HIT  = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] max_z;
  } box_t;

  // one stored node, 128 bits
  typedef struct packed {
    box_t              box;
    logic              leaf;
    logic [OBJ_W-1:0]  obj;
    logic [SIZE_W-1:0] size;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_HIT,
    ST_DONE
  } walk_state_t;

endpackage

// ===== rtl/core/bbq_req_if.sv =====
interface bbq_req_if;
  import bbq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ADDR_IN_W-1:0] node_addr;
  logic [COORD_W-1:0]   min_x;
  logic [COORD_W-1:0]   min_y;
  logic [COORD_W-1:0]   min_z;
  logic [COORD_W-1:0]   max_x;
  logic [COORD_W-1:0]   max_y;
  logic [COORD_W-1:0]   max_z;
  logic                 is_leaf;
  logic [OBJ_W-1:0]     object_id;
  logic [SIZE_W-1:0]    subtree_size;

  modport source (
    output valid, cmd, node_addr, min_x, min_y, min_z, max_x, max_y, max_z,
           is_leaf, object_id, subtree_size,
    input  ready
  );
  modport sink (
    input  valid, cmd, node_addr, min_x, min_y, min_z, max_x, max_y, max_z,
           is_leaf, object_id, subtree_size,
    output ready
  );
endinterface

// ===== rtl/core/bbq_rsp_if.sv =====
interface bbq_rsp_if;
  import bbq_pkg::*;

  logic             valid;
  logic             ready;
  logic [OBJ_W-1:0] hit_object;
  logic             kind;
  logic             truncated;
  logic             last;

  modport source (
    output valid, hit_object, kind, truncated, last,
    input  ready
  );
  modport sink (
    input  valid, hit_object, kind, truncated, last,
    output ready
  );
endinterface

// ===== rtl/core/bbq_cfg_if.sv =====
interface bbq_cfg_if;
  import bbq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/core/bbq_node_mem.sv =====
module bbq_node_mem
  import bbq_pkg::*;
#(
  parameter int unsigned DEPTH = NODES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  node_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output node_t         rd_data
);

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bbq_overlap.sv =====
module bbq_overlap
  import bbq_pkg::*;
(
  input  box_t qbox,
  input  box_t nbox,
  output logic meet
);

  // separated on an axis when one min lies above the other max
  assign meet = !((qbox.min_x > nbox.max_x) || (qbox.max_x < nbox.min_x) ||
                  (qbox.min_y > nbox.max_y) || (qbox.max_y < nbox.min_y) ||
                  (qbox.min_z > nbox.max_z) || (qbox.max_z < nbox.min_z));

endmodule

// ===== rtl/core/bvh_box_overlap_query.sv =====
// Channel  Dir  Word                                   Accepted when
// req      in   write node / run query, box + node     req.valid && req.ready
// rsp      out  hit object, kind, truncated, last      rsp.valid && rsp.ready
// cfg      in   register index + data                  cfg.valid && cfg.ready
//
// A query starts, then for each visited node reads the store, then does
// the overlap test and index step; each hit sends a hit word, and the
// walk ends with a done word, early when stop mode or the hit cap ends
// it. One read port, one overlap unit. Reset clears the sequencer, hit
// count, output valid and node count and sets stop mode; the node store
// is not cleared. A stalled rsp holds the walk at the next word.
module bvh_box_overlap_query
  import bbq_pkg::*;
#(
  parameter int unsigned NODES    = NODES_DEF,
  parameter int unsigned MAX_HITS = MAX_HITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bbq_req_if.sink   req,
  bbq_rsp_if.source rsp,
  bbq_cfg_if.sink   cfg
);

  localparam int unsigned AW = $clog2(NODES);
  // walk index must hold the node count plus one full skip
  localparam int unsigned IW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
  localparam logic [IW-1:0]     NODES_I  = IW'(NODES);
  localparam logic [HITS_W-1:0] HITS_CAP = HITS_W'(MAX_HITS);

  // config registers
  logic [COUNT_W-1:0] node_count;
  logic               stop_at_first;

  // walk state
  walk_state_t        state, state_next;
  box_t               qbox;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      limit;
  logic [HITS_W-1:0]  hits;
  logic               trunc;

  // output word register
  logic               out_valid;
  logic [OBJ_W-1:0]   out_obj;
  logic               out_kind;
  logic               out_trunc;
  logic               out_last;

  // datapath
  logic               req_fire;
  logic               is_query;
  logic [IW-1:0]      wr_addr_ext;
  logic [IW-1:0]      count_ext;
  logic               wr_en;
  logic               rd_en;
  node_t              wr_node;
  node_t              rd_node;
  box_t               req_box;
  logic               meet;
  logic               more;
  logic               out_free;
  logic [SIZE_W-1:0]  step;
  logic [IW-1:0]      idx_adv;

  // sequencer strobes
  logic               start;
  logic               step_idx;
  logic               load_hit;
  logic               load_done;
  logic               set_trunc;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign req_fire    = req.valid && req.ready;
  assign is_query    = (cmd_t'(req.cmd) == CMD_QUERY);
  assign wr_addr_ext = IW'(req.node_addr);
  assign count_ext   = IW'(node_count);

  // writes to a slot past the store are dropped
  assign wr_en = req_fire && !is_query && (wr_addr_ext < NODES_I);

  assign req_box = '{min_x: req.min_x, min_y: req.min_y, min_z: req.min_z,
                     max_x: req.max_x, max_y: req.max_y, max_z: req.max_z};
  assign wr_node = '{box: req_box, leaf: req.is_leaf, obj: req.object_id,
                     size: req.subtree_size};

  assign more  = (idx < limit);
  assign rd_en = (state == ST_FETCH) && more;

  bbq_node_mem #(
    .DEPTH   (NODES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr_ext[AW-1:0]),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_node)
  );

  bbq_overlap u_overlap (
    .qbox (qbox),
    .nbox (rd_node.box),
    .meet (meet)
  );

  // a missed inner node skips its subtree (size zero counts as one)
  always_comb begin
    if (rd_node.leaf || meet || (rd_node.size == '0)) begin
      step = SIZE_W'(1);
    end else begin
      step = rd_node.size;
    end
  end
  assign idx_adv = idx + IW'(step);

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start      = 1'b0;
    step_idx   = 1'b0;
    load_hit   = 1'b0;
    load_done  = 1'b0;
    set_trunc  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && is_query) begin
          start      = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = more ? ST_EVAL : ST_DONE;
      end
      ST_EVAL: begin
        if (rd_node.leaf && meet) begin
          if (hits >= HITS_CAP) begin
            set_trunc  = 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_HIT;
          end
        end else begin
          step_idx   = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_HIT: begin
        // rd_node holds: no read is issued until the next fetch
        if (out_free) begin
          load_hit = 1'b1;
          if (stop_at_first) begin
            state_next = ST_DONE;
          end else begin
            step_idx   = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_done  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= '0;
      stop_at_first <= 1'b1;
      hits          <= '0;
      trunc         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_idx_t'(cfg.index))
          REG_NODE_COUNT:    node_count    <= cfg.data[COUNT_W-1:0];
          REG_STOP_AT_FIRST: stop_at_first <= cfg.data[0];
        endcase
      end
      if (start) begin
        hits  <= '0;
        trunc <= 1'b0;
      end else begin
        if (load_hit) begin
          hits <= hits + HITS_W'(1);
        end
        if (set_trunc) begin
          trunc <= 1'b1;
        end
      end
      if (load_hit || load_done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      qbox  <= req_box;
      idx   <= '0;
      limit <= (count_ext > NODES_I) ? NODES_I : count_ext;
    end else if (step_idx) begin
      idx <= idx_adv;
    end
    if (load_hit) begin
      out_obj   <= rd_node.obj;
      out_kind  <= KIND_HIT;
      out_trunc <= 1'b0;
      out_last  <= 1'b0;
    end else if (load_done) begin
      out_obj   <= '0;
      out_kind  <= KIND_DONE;
      out_trunc <= trunc;
      out_last  <= 1'b1;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.hit_object = out_obj;
  assign rsp.kind       = out_kind;
  assign rsp.truncated  = out_trunc;
  assign rsp.last       = out_last;

endmodule
